// File: hw/rtl/bba_pkg.sv
`default_nettype none

package bba_pkg;

   localparam int WORD_BITS   = 32;
   localparam int MAX_BLOCKS  = 1024;
   localparam int MAP_WORDS   = MAX_BLOCKS / WORD_BITS;
   localparam int WORD_IDX_W  = $clog2(MAP_WORDS);
   localparam int BIT_IDX_W   = $clog2(WORD_BITS);
   localparam int BLOCK_IDX_W = 10;
   localparam int OFFSET_W    = 24;
   localparam int WIDTH_W     = 15;
   localparam int NBLK_W      = 11;
   localparam int STATUS_W    = 3;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = WIDTH_W;
   localparam int DIV_CNT_W   = $clog2(OFFSET_W);

   localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(16);
   localparam logic [NBLK_W-1:0]  NBLK_RESET  = NBLK_W'(1024);

   localparam logic OP_ALLOC = 1'b0;

   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_WIDTH = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_BLOCKS  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 3'd0,
      STAT_FULL     = 3'd1,
      STAT_RANGE    = 3'd2,
      STAT_MISALIGN = 3'd3,
      STAT_DOUBLE   = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      ST_FILL,
      ST_IDLE,
      ST_A_READ,
      ST_A_CHECK,
      ST_A_HINT,
      ST_F_RANGE,
      ST_F_DIV,
      ST_F_CHECK,
      ST_F_TEST,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      RD_SCAN,
      RD_NEXT,
      RD_FREE
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_FILL,
      WR_ALLOC,
      WR_FREE
   } wr_sel_type;

   typedef enum logic [2:0] {
      RES_NONE,
      RES_FULL,
      RES_RANGE,
      RES_MISALIGN,
      RES_DOUBLE,
      RES_ALLOC_OK,
      RES_FREE_OK
   } res_sel_type;

   typedef struct packed {
      logic        capture;
      rd_sel_type  rd_sel;
      wr_sel_type  wr_sel;
      logic        fill_step;
      logic        scan_inc;
      logic        hint_alloc;
      logic        hint_free;
      logic        div_init;
      logic        div_step;
      res_sel_type res_sel;
      logic        rsp_load;
   } cmd_type;

   typedef struct packed {
      logic fill_req;
      logic fill_last;
      logic req_is_alloc;
      logic scan_in_pool;
      logic next_in_pool;
      logic word_zero;
      logic out_of_range;
      logic div_last;
      logic misaligned;
      logic bit_set;
      logic slot_free;
   } stat_type;

endpackage

`default_nettype wire

// File: hw/rtl/bba_ctrl.sv
`default_nettype none

module bba_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire bba_pkg::stat_type stat,
   output bba_pkg::cmd_type       cmd
);
   import bba_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_FILL: begin
            if (stat.fill_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = stat.req_is_alloc ? ST_A_READ : ST_F_RANGE;
         end
         ST_A_READ: begin
            state_in = stat.scan_in_pool ? ST_A_CHECK : ST_DONE;
         end
         ST_A_CHECK: begin
            if (!stat.word_zero) state_in = ST_A_HINT;
            else if (stat.next_in_pool) state_in = ST_A_READ;
            else state_in = ST_DONE;
         end
         ST_A_HINT: begin
            state_in = ST_DONE;
         end
         ST_F_RANGE: begin
            state_in = stat.out_of_range ? ST_DONE : ST_F_DIV;
         end
         ST_F_DIV: begin
            if (stat.div_last) state_in = ST_F_CHECK;
         end
         ST_F_CHECK: begin
            state_in = stat.misaligned ? ST_DONE : ST_F_TEST;
         end
         ST_F_TEST: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (stat.slot_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
      // A new pool size restarts the bitmap sweep from any state.
      if (stat.fill_req) state_in = ST_FILL;
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_FILL: begin
            cmd.wr_sel    = WR_FILL;
            cmd.fill_step = 1'b1;
         end
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_A_READ: begin
            cmd.rd_sel = RD_SCAN;
            if (!stat.scan_in_pool) cmd.res_sel = RES_FULL;
         end
         ST_A_CHECK: begin
            if (!stat.word_zero) begin
               cmd.wr_sel = WR_ALLOC;
               cmd.rd_sel = RD_NEXT;
            end else if (stat.next_in_pool) begin
               cmd.scan_inc = 1'b1;
            end else begin
               cmd.res_sel = RES_FULL;
            end
         end
         ST_A_HINT: begin
            cmd.hint_alloc = 1'b1;
            cmd.res_sel    = RES_ALLOC_OK;
         end
         ST_F_RANGE: begin
            if (stat.out_of_range) cmd.res_sel = RES_RANGE;
            else cmd.div_init = 1'b1;
         end
         ST_F_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_F_CHECK: begin
            if (stat.misaligned) cmd.res_sel = RES_MISALIGN;
            else cmd.rd_sel = RD_FREE;
         end
         ST_F_TEST: begin
            if (stat.bit_set) begin
               cmd.res_sel = RES_DOUBLE;
            end else begin
               cmd.wr_sel    = WR_FREE;
               cmd.hint_free = 1'b1;
               cmd.res_sel   = RES_FREE_OK;
            end
         end
         ST_DONE: begin
            cmd.rsp_load = stat.slot_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: hw/rtl/bba_datapath.sv
`default_nettype none

module bba_datapath (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_opcode,
   input  wire logic [bba_pkg::OFFSET_W-1:0]     req_offset,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [bba_pkg::STATUS_W-1:0]          rsp_status,
   output logic [bba_pkg::BLOCK_IDX_W-1:0]       rsp_block_index,
   output logic [bba_pkg::OFFSET_W-1:0]          rsp_byte_offset,
   input  wire logic                             csr_write,
   input  wire logic [bba_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [bba_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire bba_pkg::cmd_type                 cmd,
   output bba_pkg::stat_type                     stat
);
   import bba_pkg::*;

   localparam int LINE_W = NBLK_W - BIT_IDX_W;

   function automatic logic [WORD_BITS-1:0] fill_word(input logic [WORD_IDX_W-1:0] w,
                                                      input logic [NBLK_W-1:0] n);
      logic [LINE_W-1:0] wl;
      wl = LINE_W'(w);
      if (n[NBLK_W-1:BIT_IDX_W] > wl) fill_word = '1;
      else if (n[NBLK_W-1:BIT_IDX_W] == wl) fill_word = ~({WORD_BITS{1'b1}} << n[BIT_IDX_W-1:0]);
      else fill_word = '0;
   endfunction

   function automatic logic [BIT_IDX_W-1:0] lowest_bit(input logic [WORD_BITS-1:0] v);
      logic [BIT_IDX_W-1:0] b;
      b = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) b = BIT_IDX_W'(i);
      end
      lowest_bit = b;
   endfunction

   // Configuration.
   logic [WIDTH_W-1:0]    width_ff;
   logic [NBLK_W-1:0]     nblk_ff;
   logic [WIDTH_W-1:0]    eff_width;
   logic [NBLK_W-1:0]     pool_n;

   // Bitmap memory and its registered read port.
   logic [WORD_BITS-1:0]  map_mem [MAP_WORDS];
   logic [WORD_BITS-1:0]  rd_data_ff;
   logic [WORD_IDX_W-1:0] rd_addr;
   logic [WORD_IDX_W-1:0] wr_addr;
   logic [WORD_BITS-1:0]  wr_data;
   logic                  wr_en;

   logic [WORD_IDX_W-1:0]   fill_cnt_ff;
   logic [WORD_IDX_W-1:0]   hint_ff;
   logic [WORD_IDX_W-1:0]   scan_ff;
   logic [WORD_IDX_W:0]     scan_nxt;
   logic [OFFSET_W-1:0]     off_ff;
   logic [BIT_IDX_W-1:0]    low_bit;
   logic [WORD_BITS-1:0]    alloc_word;
   logic                    new_nz_ff;
   logic [BLOCK_IDX_W-1:0]  alloc_idx_ff;
   logic [WORD_IDX_W-1:0]   hint_alloc_val;

   // Restoring divider state.
   logic [WIDTH_W:0]        rem_ff;
   logic [WIDTH_W:0]        rem_in;
   logic [WIDTH_W:0]        rem_shift;
   logic                    rem_ge;
   logic [OFFSET_W-1:0]     quo_ff;
   logic [DIV_CNT_W-1:0]    div_cnt_ff;
   logic [WORD_IDX_W-1:0]   free_word;
   logic [BIT_IDX_W-1:0]    free_bit;

   logic [NBLK_W+WIDTH_W-1:0]      limit;
   logic [BLOCK_IDX_W+WIDTH_W-1:0] bytes_prod;

   status_type              res_status_ff;
   logic [BLOCK_IDX_W-1:0]  res_index_ff;
   logic [OFFSET_W-1:0]     res_bytes_ff;
   logic                    rsp_valid_ff;
   status_type              rsp_status_ff;
   logic [BLOCK_IDX_W-1:0]  rsp_index_ff;
   logic [OFFSET_W-1:0]     rsp_bytes_ff;

   assign eff_width = (width_ff == '0) ? WIDTH_W'(1) : width_ff;
   assign pool_n    = (nblk_ff > NBLK_W'(MAX_BLOCKS)) ? NBLK_W'(MAX_BLOCKS) : nblk_ff;

   assign free_word = quo_ff[WORD_IDX_W+BIT_IDX_W-1:BIT_IDX_W];
   assign free_bit  = quo_ff[BIT_IDX_W-1:0];
   assign scan_nxt  = {1'b0, scan_ff} + 1'b1;

   assign low_bit    = lowest_bit(rd_data_ff);
   assign alloc_word = rd_data_ff & ~({{(WORD_BITS-1){1'b0}}, 1'b1} << low_bit);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
         nblk_ff  <= NBLK_RESET;
      end else if (csr_write) begin
         if (csr_index == CSR_BLOCK_WIDTH) width_ff <= csr_wdata;
         if (csr_index == CSR_NUM_BLOCKS)  nblk_ff  <= csr_wdata[NBLK_W-1:0];
      end
   end

   always_comb begin
      unique case (cmd.rd_sel)
         RD_SCAN: rd_addr = scan_ff;
         RD_NEXT: rd_addr = scan_nxt[WORD_IDX_W-1:0];
         RD_FREE: rd_addr = free_word;
         default: rd_addr = scan_ff;
      endcase
   end

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = fill_cnt_ff;
      wr_data = fill_word(fill_cnt_ff, pool_n);
      unique case (cmd.wr_sel)
         WR_FILL: begin
            wr_addr = fill_cnt_ff;
         end
         WR_ALLOC: begin
            wr_addr = scan_ff;
            wr_data = alloc_word;
         end
         WR_FREE: begin
            wr_addr = free_word;
            wr_data = rd_data_ff | ({{(WORD_BITS-1){1'b0}}, 1'b1} << free_bit);
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) map_mem[wr_addr] <= wr_data;
      rd_data_ff <= map_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset || stat.fill_req) begin
         fill_cnt_ff <= '0;
      end else if (cmd.fill_step) begin
         fill_cnt_ff <= fill_cnt_ff + 1'b1;
      end
   end

   // The new hint is the word just used, the next nonzero pool word, or 0.
   always_comb begin
      if (new_nz_ff) hint_alloc_val = scan_ff;
      else if (stat.next_in_pool && (rd_data_ff != '0)) hint_alloc_val = scan_nxt[WORD_IDX_W-1:0];
      else hint_alloc_val = '0;
   end

   always_ff @(posedge clock) begin
      if (reset || stat.fill_req) begin
         hint_ff <= '0;
      end else if (cmd.hint_alloc) begin
         hint_ff <= hint_alloc_val;
      end else if (cmd.hint_free) begin
         hint_ff <= free_word;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         off_ff  <= req_offset;
         scan_ff <= hint_ff;
      end else if (cmd.scan_inc) begin
         scan_ff <= scan_nxt[WORD_IDX_W-1:0];
      end
      if (cmd.wr_sel == WR_ALLOC) begin
         new_nz_ff    <= (alloc_word != '0);
         alloc_idx_ff <= BLOCK_IDX_W'({scan_ff, low_bit});
      end
   end

   assign rem_shift = {rem_ff[WIDTH_W-1:0], quo_ff[OFFSET_W-1]};
   assign rem_ge    = (rem_shift >= {1'b0, eff_width});
   assign rem_in    = rem_ge ? (rem_shift - {1'b0, eff_width}) : rem_shift;

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rem_ff     <= '0;
         quo_ff     <= off_ff;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff     <= rem_in;
         quo_ff     <= {quo_ff[OFFSET_W-2:0], rem_ge};
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
   end

   assign limit      = eff_width * pool_n;
   assign bytes_prod = alloc_idx_ff * eff_width;

   always_ff @(posedge clock) begin
      unique case (cmd.res_sel) inside
         RES_FULL, RES_RANGE, RES_MISALIGN, RES_DOUBLE: begin
            unique case (cmd.res_sel)
               RES_FULL:     res_status_ff <= STAT_FULL;
               RES_RANGE:    res_status_ff <= STAT_RANGE;
               RES_MISALIGN: res_status_ff <= STAT_MISALIGN;
               default:      res_status_ff <= STAT_DOUBLE;
            endcase
            res_index_ff <= '0;
            res_bytes_ff <= '0;
         end
         RES_ALLOC_OK: begin
            res_status_ff <= STAT_OK;
            res_index_ff  <= alloc_idx_ff;
            // Byte offsets past the 24-bit range saturate.
            res_bytes_ff  <= bytes_prod[BLOCK_IDX_W+WIDTH_W-1:OFFSET_W] != '0 ?
                             '1 : bytes_prod[OFFSET_W-1:0];
         end
         RES_FREE_OK: begin
            res_status_ff <= STAT_OK;
            res_index_ff  <= quo_ff[BLOCK_IDX_W-1:0];
            res_bytes_ff  <= '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_index_ff  <= res_index_ff;
         rsp_bytes_ff  <= res_bytes_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_block_index = rsp_index_ff;
   assign rsp_byte_offset = rsp_bytes_ff;

   always_comb begin
      stat.fill_req     = csr_write && (csr_index == CSR_NUM_BLOCKS);
      stat.fill_last    = (fill_cnt_ff == WORD_IDX_W'(MAP_WORDS - 1));
      stat.req_is_alloc = (req_opcode == OP_ALLOC);
      stat.scan_in_pool = (NBLK_W'({scan_ff, {BIT_IDX_W{1'b0}}}) < pool_n);
      stat.next_in_pool = (NBLK_W'({scan_nxt, {BIT_IDX_W{1'b0}}}) < pool_n);
      stat.word_zero    = (rd_data_ff == '0);
      stat.out_of_range = ((NBLK_W+WIDTH_W)'(off_ff) >= limit);
      stat.div_last     = (div_cnt_ff == DIV_CNT_W'(OFFSET_W - 1));
      stat.misaligned   = (rem_ff != '0);
      stat.bit_set      = rd_data_ff[free_bit];
      stat.slot_free    = !rsp_valid_ff || !rsp_stall;
   end

endmodule

`default_nettype wire

// File: hw/rtl/bitmap_block_allocator.sv
`default_nettype none

// Bitmap block allocator for one pool of up to 1024 equal blocks. Each request word
// (allocate, or free by byte offset) yields exactly one response word. The pool is
// served one request at a time. An allocate scans the bitmap words from the hint word
// onward and answers pool full when no word inside the pool has a free bit. The scan
// is set by the single read port of the 32-word bitmap memory. A free first checks
// the offset range, then runs the 24-step restoring divider that turns the offset into
// a block index, and answers misaligned when the division leaves a remainder.
// After reset and after every write of num_blocks the bitmap is refilled by a sweep
// of its 32 words, during which req_stall stays high. A finished response waits in an
// output register, so the next request is taken while the previous response stalls.
module bitmap_block_allocator (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic                             req_opcode,
   input  wire logic [bba_pkg::OFFSET_W-1:0]     req_offset,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [bba_pkg::STATUS_W-1:0]          rsp_status,
   output logic [bba_pkg::BLOCK_IDX_W-1:0]       rsp_block_index,
   output logic [bba_pkg::OFFSET_W-1:0]          rsp_byte_offset,
   input  wire logic                             csr_write,
   input  wire logic [bba_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [bba_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import bba_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   bba_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_opcode      (req_opcode),
      .req_offset      (req_offset),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_block_index (rsp_block_index),
      .rsp_byte_offset (rsp_byte_offset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .cmd             (cmd),
      .stat            (stat)
   );

endmodule

`default_nettype wire

// File: hw/rtl/bba_checker.sv
`default_nettype none

module bba_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_valid,
   input wire logic                             req_stall,
   input wire logic                             req_opcode,
   input wire logic [bba_pkg::OFFSET_W-1:0]     req_offset,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_stall,
   input wire logic [bba_pkg::STATUS_W-1:0]     rsp_status,
   input wire logic [bba_pkg::BLOCK_IDX_W-1:0]  rsp_block_index,
   input wire logic [bba_pkg::OFFSET_W-1:0]     rsp_byte_offset,
   input wire logic                             csr_write,
   input wire logic [bba_pkg::CSR_INDEX_W-1:0]  csr_index,
   input wire logic [bba_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import bba_pkg::*;

   // A held response word keeps its valid.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_status) && $stable(rsp_block_index)
                                  && $stable(rsp_byte_offset))
      else $error("stalled response word changed");

   // Requests are served one at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while one is in service");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STAT_OK) || (rsp_status == STAT_FULL)
                    || (rsp_status == STAT_RANGE) || (rsp_status == STAT_MISALIGN)
                    || (rsp_status == STAT_DOUBLE))
      else $error("undefined response status");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STAT_OK) |-> (rsp_block_index == '0)
                                               && (rsp_byte_offset == '0))
      else $error("error response carries a nonzero index or offset");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);

`default_nettype wire
